// ===== sv/tpa_pkg.sv =====
// Package for the triangle primitive assembler.
// Holds command, mode and status codes and the shared check struct.
// No dependencies.
`timescale 1ns / 1ps

package tpa_pkg;

  localparam int INDEX_BITS_DEF = 16;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  localparam logic [1:0] ST_VERTEX = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_MID   = 2'd1;
  localparam logic [1:0] CORNER_LAST  = 2'd2;

  // Result of the count check on a start transaction
  typedef struct packed {
    logic ok;       // count legal for the mode
    logic nonzero;  // expanded list has at least one vertex
  } start_chk_t;

endpackage

// ===== sv/triangle_primitive_assembler.sv =====
// Top level of the triangle primitive assembler: input register, draw state,
// result register. Depends on tpa_pkg, tpa_count_check and tpa_corner.
//
//   channel | handshake            | fields                                          | role
//   in      | in_valid/in_ready    | cmd, first_vertex, vertex_count, prim_mode      | sink
//   out     | out_valid/out_ready  | vertex_element, triangle_start, last_vertex, status | source
//
// One transaction per cycle sustained while the output is not stalled; each input gives exactly one result.
// The accepting edge loads the input register; the result register and out_valid
// load from it once the output can move on.
// Synchronous active-high reset clears draw state and both valid flags.
// Output stall holds the result register and the input register; in_ready
// drops only while the input register is full and cannot move on.
`timescale 1ns / 1ps

module triangle_primitive_assembler #(
  parameter int INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [INDEX_BITS-1:0] first_vertex,
  input  logic [INDEX_BITS-1:0] vertex_count,
  input  logic [1:0]            prim_mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS:0]   vertex_element,
  output logic                  triangle_start,
  output logic                  last_vertex,
  output logic [1:0]            status
);
  import tpa_pkg::*;

  // input register
  logic                  in_q_valid;
  logic                  cmd_q;
  logic [INDEX_BITS-1:0] first_q;
  logic [INDEX_BITS-1:0] count_q;
  logic [1:0]            mode_q;

  // draw state
  logic                  draw_active;
  logic [1:0]            held_mode;
  logic [INDEX_BITS-1:0] held_first;
  logic [INDEX_BITS+1:0] vertices_left;
  logic [INDEX_BITS-1:0] triangle_number;
  logic [1:0]            corner_number;

  logic                  draw_active_next;
  logic [1:0]            held_mode_next;
  logic [INDEX_BITS-1:0] held_first_next;
  logic [INDEX_BITS+1:0] vertices_left_next;
  logic [INDEX_BITS-1:0] triangle_number_next;
  logic [1:0]            corner_number_next;

  logic [INDEX_BITS:0]   elem_next;
  logic                  tstart_next;
  logic                  last_next;
  logic [1:0]            status_next;

  start_chk_t            chk;
  logic [INDEX_BITS+1:0] total;
  logic [INDEX_BITS:0]   corner_elem;
  logic                  advance;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  tpa_count_check #(.INDEX_BITS(INDEX_BITS)) u_check (
    .vertex_count (count_q),
    .prim_mode    (mode_q),
    .chk          (chk),
    .total        (total)
  );

  tpa_corner #(.INDEX_BITS(INDEX_BITS)) u_corner (
    .held_mode       (held_mode),
    .held_first      (held_first),
    .triangle_number (triangle_number),
    .corner_number   (corner_number),
    .element         (corner_elem)
  );

  always_comb begin
    draw_active_next     = draw_active;
    held_mode_next       = held_mode;
    held_first_next      = held_first;
    vertices_left_next   = vertices_left;
    triangle_number_next = triangle_number;
    corner_number_next   = corner_number;
    elem_next            = '0;
    tstart_next          = 1'b0;
    last_next            = 1'b0;
    status_next          = ST_IDLE;

    if (cmd_q == CMD_START) begin
      triangle_number_next = '0;
      corner_number_next   = CORNER_FIRST;
      if (chk.ok) begin
        held_mode_next     = mode_q;
        held_first_next    = first_q;
        vertices_left_next = total;
        draw_active_next   = chk.nonzero;
        status_next        = ST_ACCEPT;
      end else begin
        vertices_left_next = '0;
        draw_active_next   = 1'b0;
        status_next        = ST_REJECT;
      end
    end else if (draw_active && vertices_left != '0) begin
      elem_next          = corner_elem;
      tstart_next        = (corner_number == CORNER_FIRST);
      last_next          = (vertices_left == (INDEX_BITS+2)'(1));
      status_next        = ST_VERTEX;
      vertices_left_next = vertices_left - (INDEX_BITS+2)'(1);
      draw_active_next   = (vertices_left != (INDEX_BITS+2)'(1));
      if (corner_number >= CORNER_LAST) begin
        corner_number_next   = CORNER_FIRST;
        triangle_number_next = triangle_number + INDEX_BITS'(1);
      end else begin
        corner_number_next = corner_number + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q   <= cmd;
      first_q <= first_vertex;
      count_q <= vertex_count;
      mode_q  <= prim_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_active     <= 1'b0;
      held_mode       <= MODE_LIST;
      held_first      <= '0;
      vertices_left   <= '0;
      triangle_number <= '0;
      corner_number   <= CORNER_FIRST;
    end else if (advance) begin
      draw_active     <= draw_active_next;
      held_mode       <= held_mode_next;
      held_first      <= held_first_next;
      vertices_left   <= vertices_left_next;
      triangle_number <= triangle_number_next;
      corner_number   <= corner_number_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vertex_element <= elem_next;
      triangle_start <= tstart_next;
      last_vertex    <= last_next;
      status         <= status_next;
    end
  end

endmodule

// ===== sv/tpa_count_check.sv =====
// Count check for a start transaction: legality per mode and expanded length.
// Depends on tpa_pkg.
`timescale 1ns / 1ps

module tpa_count_check #(
  parameter int INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0] vertex_count,
  input  logic [1:0]            prim_mode,
  output tpa_pkg::start_chk_t   chk,
  output logic [INDEX_BITS+1:0] total
);
  import tpa_pkg::*;

  // count mod 3 via base-4 digit sum (4 = 1 mod 3)
  localparam int DIGITS = (INDEX_BITS + 1) / 2;
  localparam int PAD_W  = 2 * DIGITS;
  localparam int SUM_W  = $clog2(3 * DIGITS + 1);

  logic [PAD_W-1:0] cnt_pad;
  logic [SUM_W-1:0] dsum;
  logic [7:0]       fold0;
  logic [3:0]       fold1;
  logic [2:0]       fold2;
  logic             div3;
  logic [INDEX_BITS-1:0] cnt_m2;
  logic [INDEX_BITS+1:0] cnt_m2_x;

  always_comb begin
    cnt_pad = PAD_W'(vertex_count);
    dsum = '0;
    for (int i = 0; i < DIGITS; i++) begin
      dsum = dsum + SUM_W'(cnt_pad[2*i +: 2]);
    end
    fold0 = 8'(dsum);
    fold1 = 4'(fold0[7:6]) + 4'(fold0[5:4]) + 4'(fold0[3:2]) + 4'(fold0[1:0]);
    fold2 = 3'(fold1[3:2]) + 3'(fold1[1:0]);
    div3  = (fold2 == 3'd0) || (fold2 == 3'd3) || (fold2 == 3'd6);
  end

  assign cnt_m2   = vertex_count - INDEX_BITS'(2);
  assign cnt_m2_x = (INDEX_BITS+2)'(cnt_m2);

  always_comb begin
    chk   = '0;
    total = '0;
    unique case (prim_mode)
      MODE_LIST: begin
        chk.ok      = div3;
        chk.nonzero = (vertex_count != '0);
        total       = (INDEX_BITS+2)'(vertex_count);
      end
      MODE_STRIP, MODE_FAN: begin
        chk.ok      = (vertex_count >= INDEX_BITS'(3));
        chk.nonzero = 1'b1;
        total       = (cnt_m2_x << 1) + cnt_m2_x;
      end
      default: begin
        chk.ok      = 1'b0;
        chk.nonzero = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/tpa_corner.sv =====
// Element number of the current corner for list, strip and fan draws.
// Depends on tpa_pkg.
`timescale 1ns / 1ps

module tpa_corner #(
  parameter int INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
  input  logic [1:0]            held_mode,
  input  logic [INDEX_BITS-1:0] held_first,
  input  logic [INDEX_BITS-1:0] triangle_number,
  input  logic [1:0]            corner_number,
  output logic [INDEX_BITS:0]   element
);
  import tpa_pkg::*;

  logic [INDEX_BITS+1:0] t_x;
  logic [INDEX_BITS+1:0] c_x;
  logic [INDEX_BITS+1:0] off;
  logic [INDEX_BITS+1:0] sum;

  assign t_x = (INDEX_BITS+2)'(triangle_number);
  assign c_x = (INDEX_BITS+2)'(corner_number);

  always_comb begin
    unique case (held_mode)
      MODE_STRIP: begin
        // odd strip triangles swap the first two corners
        if (triangle_number[0] && corner_number == CORNER_FIRST) begin
          off = t_x + (INDEX_BITS+2)'(1);
        end else if (triangle_number[0] && corner_number == CORNER_MID) begin
          off = t_x;
        end else begin
          off = t_x + c_x;
        end
      end
      MODE_FAN: begin
        off = (corner_number == CORNER_FIRST) ? '0 : t_x + c_x;
      end
      default: begin
        off = (t_x << 1) + t_x + c_x;
      end
    endcase
  end

  assign sum     = (INDEX_BITS+2)'(held_first) + off;
  assign element = sum[INDEX_BITS:0];

endmodule

// ===== sv/tpa_checker.sv =====
// Port-level checks for the triangle primitive assembler, bound to the top.
// Depends on tpa_pkg and triangle_primitive_assembler.
`timescale 1ns / 1ps

module tpa_checker #(
  parameter int INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [INDEX_BITS:0]   vertex_element,
  input logic                  triangle_start,
  input logic                  last_vertex,
  input logic [1:0]            status
);
  import tpa_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_element) &&
      $stable(status) && $stable(triangle_start) && $stable(last_vertex))
    else $error("result changed while stalled");

  // non-vertex results carry zero fields
  a_nonvertex_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VERTEX |->
      vertex_element == '0 && !triangle_start && !last_vertex)
    else $error("non-vertex result with nonzero fields");

  // last vertex is always a closing corner, never an opening one
  a_last_not_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_VERTEX |-> !(triangle_start && last_vertex))
    else $error("last vertex flagged as triangle start");

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_primitive_assembler tpa_checker #(.INDEX_BITS(INDEX_BITS)) u_tpa_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .vertex_element (vertex_element),
  .triangle_start (triangle_start),
  .last_vertex    (last_vertex),
  .status         (status)
);

// ===== tb/sv/triangle_primitive_assembler_tb.sv =====
// Self-checking testbench for triangle_primitive_assembler: directed table of
// draws, then random draw sequences under varying backpressure.
// Depends on tpa_pkg and the assembler RTL.
`timescale 1ns / 1ps

module triangle_primitive_assembler_tb;
  import tpa_pkg::*;

  localparam int IB = INDEX_BITS_DEF;
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [IB:0] element;
    logic        tri_start;
    logic        last;
    logic [1:0]  st;
  } asm_out_t;

  typedef struct packed {
    logic          c;
    logic [IB-1:0] fv;
    logic [IB-1:0] cnt;
    logic [1:0]    md;
    logic          typed;
    asm_out_t      want;
  } row_t;

  localparam asm_out_t IDLE_R    = '{'0, 1'b0, 1'b0, ST_IDLE};
  localparam asm_out_t ACC_R     = '{'0, 1'b0, 1'b0, ST_ACCEPT};
  localparam asm_out_t REJ_R     = '{'0, 1'b0, 1'b0, ST_REJECT};
  localparam asm_out_t FAN_HUB_R = '{17'h0ffff, 1'b1, 1'b0, ST_VERTEX};
  localparam asm_out_t NO_WANT   = '0;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          cmd = CMD_ADVANCE;
  logic [IB-1:0] first_vertex = '0;
  logic [IB-1:0] vertex_count = '0;
  logic [1:0]    prim_mode = MODE_LIST;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [IB:0]   vertex_element;
  logic          triangle_start;
  logic          last_vertex;
  logic [1:0]    status;

  // predictor state
  logic          draw_on = 1'b0;
  logic [1:0]    mode_q = MODE_LIST;
  logic [IB-1:0] first_q = '0;
  logic [17:0]   left_q = '0;
  logic [15:0]   tri_q = '0;
  logic [1:0]    corner_q = CORNER_FIRST;

  asm_out_t pending_vertices[$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       tx_idle_pct = 19;
  int       rx_idle_pct = 78;
  logic     long_hold_go = 1'b0;
  logic     long_hold_done = 1'b0;
  int       hold_left = 0;

  row_t plan [0:26] = '{
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b1, IDLE_R},
    '{CMD_START,   16'h1234, 16'h0000, MODE_LIST,  1'b1, ACC_R},   // empty list
    '{CMD_ADVANCE, 16'hffff, 16'hffff, MODE_BAD,   1'b1, IDLE_R},
    '{CMD_START,   16'h0000, 16'h0004, MODE_LIST,  1'b1, REJ_R},
    '{CMD_START,   16'h0000, 16'h0006, MODE_BAD,   1'b1, REJ_R},
    '{CMD_START,   16'h0000, 16'h0002, MODE_STRIP, 1'b1, REJ_R},
    '{CMD_START,   16'hffff, 16'hffff, MODE_FAN,   1'b1, ACC_R},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b1, FAN_HUB_R},
    // restart mid-draw; element crosses into bit 16
    '{CMD_START,   16'hfffd, 16'h0004, MODE_STRIP, 1'b1, ACC_R},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'hffff, 16'hffff, MODE_BAD,   1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h5555, 16'haaaa, MODE_FAN,   1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b1, IDLE_R},
    '{CMD_START,   16'h0000, 16'h0003, MODE_FAN,   1'b1, ACC_R},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_START,   16'h0007, 16'h0003, MODE_LIST,  1'b1, ACC_R},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b0, NO_WANT},
    '{CMD_START,   16'h0000, 16'hffff, MODE_LIST,  1'b1, ACC_R},
    // bad mode while a draw runs drops the draw
    '{CMD_START,   16'h0000, 16'hffff, MODE_BAD,   1'b1, REJ_R},
    '{CMD_ADVANCE, 16'h0000, 16'h0000, MODE_LIST,  1'b1, IDLE_R}
  };

  triangle_primitive_assembler #(.INDEX_BITS(IB)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .first_vertex   (first_vertex),
    .vertex_count   (vertex_count),
    .prim_mode      (prim_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vertex_element (vertex_element),
    .triangle_start (triangle_start),
    .last_vertex    (last_vertex),
    .status         (status)
  );

  always #10 clk = ~clk;

  // Expand one transaction into the result it produces: a vertex or a status
  function automatic asm_out_t assemble_step(input logic c, input logic [IB-1:0] fv,
                                             input logic [IB-1:0] cnt, input logic [1:0] md);
    asm_out_t    r;
    logic        ok;
    logic [17:0] total;
    int unsigned t, cn, off;
    r = '0;
    if (c == CMD_START) begin
      ok = 1'b0;
      total = '0;
      case (md)
        MODE_LIST: begin
          ok = (cnt % 3) == 0;
          total = 18'(cnt);
        end
        MODE_STRIP, MODE_FAN: begin
          ok = cnt >= 3;
          if (ok) total = 18'(3 * (int'(cnt) - 2));
        end
        default: ok = 1'b0;
      endcase
      tri_q = '0;
      corner_q = CORNER_FIRST;
      if (ok) begin
        mode_q = md;
        first_q = fv;
        left_q = total;
        draw_on = total != 0;
        r.st = ST_ACCEPT;
      end else begin
        left_q = '0;
        draw_on = 1'b0;
        r.st = ST_REJECT;
      end
    end else if (!draw_on || left_q == 0) begin
      r.st = ST_IDLE;
    end else begin
      t = 32'(tri_q);
      cn = 32'(corner_q);
      if (mode_q == MODE_STRIP) begin
        // odd strip triangles swap their first two corners
        if (t % 2 == 1 && corner_q == CORNER_FIRST) off = t + 1;
        else if (t % 2 == 1 && corner_q == CORNER_MID) off = t;
        else off = t + cn;
      end else if (mode_q == MODE_FAN) begin
        off = (corner_q == CORNER_FIRST) ? 0 : t + cn;
      end else begin
        off = 3 * t + cn;
      end
      r.element = (IB+1)'(int'(first_q) + off);
      r.tri_start = corner_q == CORNER_FIRST;
      r.last = left_q == 1;
      r.st = ST_VERTEX;
      left_q = left_q - 18'd1;
      if (corner_q >= CORNER_LAST) begin
        corner_q = CORNER_FIRST;
        tri_q = tri_q + 16'd1;
      end else begin
        corner_q = corner_q + 2'd1;
      end
      draw_on = left_q != 0;
    end
    return r;
  endfunction

  // Offer one transaction; returns at the edge that accepts it
  task automatic issue_cmd(input logic c, input logic [IB-1:0] fv, input logic [IB-1:0] cnt,
                           input logic [1:0] md, input logic typed, input asm_out_t want);
    asm_out_t got;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    first_vertex <= fv;
    vertex_count <= cnt;
    prim_mode    <= md;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    got = assemble_step(c, fv, cnt, md);
    pending_vertices.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic random_traffic(input int n_items);
    int          stop_at, pick, n_adv, k;
    logic [1:0]  md;
    logic [IB-1:0] cnt;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed draw, sometimes cut short or overrun
        md = 2'($urandom_range(MODE_LIST, MODE_FAN));
        cnt = (md == MODE_LIST) ? IB'(3 * $urandom_range(0, 8)) : IB'($urandom_range(3, 12));
        issue_cmd(CMD_START, IB'($urandom), cnt, md, 1'b0, NO_WANT);
        n_adv = (md == MODE_LIST) ? int'(cnt) : 3 * (int'(cnt) - 2);
        if ($urandom_range(0, 9) == 0) n_adv = $urandom_range(0, n_adv);
        else if ($urandom_range(0, 4) == 0) n_adv += $urandom_range(1, 2);
        for (k = 0; k < n_adv; k++)
          issue_cmd(CMD_ADVANCE, IB'($urandom), IB'($urandom), 2'($urandom), 1'b0, NO_WANT);
      end else if (pick < 85) begin
        issue_cmd(CMD_START, IB'($urandom), IB'($urandom), 2'($urandom), 1'b0, NO_WANT);
        n_adv = $urandom_range(0, 4);
        for (k = 0; k < n_adv; k++)
          issue_cmd(CMD_ADVANCE, IB'($urandom), IB'($urandom), 2'($urandom), 1'b0, NO_WANT);
      end else begin
        issue_cmd(CMD_ADVANCE, IB'($urandom), IB'($urandom), 2'($urandom), 1'b0, NO_WANT);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_go && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  // Outputs are settled at the falling edge; the transaction completes at the next rise
  always @(negedge clk) begin
    asm_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected transaction: vertex_element %0d status %0d", vertex_element, status);
        mismatch_count++;
      end else begin
        exp_r = pending_vertices.pop_front();
        if (vertex_element !== exp_r.element) begin
          $error("vertex_element: expected %0d, got %0d", exp_r.element, vertex_element);
          mismatch_count++;
        end
        if (triangle_start !== exp_r.tri_start) begin
          $error("triangle_start: expected %0d, got %0d", exp_r.tri_start, triangle_start);
          mismatch_count++;
        end
        if (last_vertex !== exp_r.last) begin
          $error("last_vertex: expected %0d, got %0d", exp_r.last, last_vertex);
          mismatch_count++;
        end
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < $size(plan); i++)
      issue_cmd(plan[i].c, plan[i].fv, plan[i].cnt, plan[i].md, plan[i].typed, plan[i].want);
    random_traffic(515);

    tx_idle_pct = 78;
    rx_idle_pct <= 19;
    random_traffic(515);

    // no idling; the receiver's long hold-off lands at the start of this stretch
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    long_hold_go <= 1'b1;
    random_traffic(515);

    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
